// ----- rtl/ksm_pkg.sv -----
package ksm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 32;

  // Resolution mode codes.
  localparam logic [1:0] MODE_8BIT  = 2'd0;
  localparam logic [1:0] MODE_12BIT = 2'd1;
  localparam logic [1:0] MODE_10BIT = 2'd2;
  localparam logic [1:0] MODE_16BIT = 2'd3;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_PRED  = 14'b00000000000010,
    ST_DEN   = 14'b00000000000100,
    ST_DINIT = 14'b00000000001000,
    ST_DIV   = 14'b00000000010000,
    ST_DIFF1 = 14'b00000000100000,
    ST_DIFF2 = 14'b00000001000000,
    ST_MUL1  = 14'b00000010000000,
    ST_RND1  = 14'b00000100000000,
    ST_EST   = 14'b00001000000000,
    ST_OMG   = 14'b00010000000000,
    ST_MUL2  = 14'b00100000000000,
    ST_RND2  = 14'b01000000000000,
    ST_HOLD  = 14'b10000000000000
  } state_t;

endpackage

// ----- rtl/ksm_alu.sv -----
module ksm_alu import ksm_pkg::*; #(
  parameter int W = 65
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  alu_op_t      op,
  output logic [W:0]   res
);

  logic [W-1:0] b_eff;
  logic         cin;

  // For a subtract, res[W] is high when a >= b (no borrow).
  assign cin   = (op == ALU_SUB);
  assign b_eff = (op == ALU_SUB) ? ~b : b;
  assign res   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, cin};

endmodule

// ----- rtl/ksm_core.sv -----
module ksm_core import ksm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [1:0]          mode,
  input  logic                out_free,
  output logic                idle,
  output logic                done,
  output logic [VALUE_W-1:0]  result
);

  localparam int GW  = FRAC_BITS + 1;
  localparam int SW  = SAMPLE_BITS + FRAC_BITS;
  localparam int MW  = (SW > 32) ? SW : 32;
  localparam int AW  = MW + GW;
  localparam int RW  = (FRAC_BITS + 7 > 32) ? FRAC_BITS + 7 : 32;
  localparam int DW  = RW + 1;
  localparam int DDW = 33 + FRAC_BITS;
  localparam int CW  = $clog2(GW);

  localparam logic [31:0]  Q_TENTH = 32'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0]  Q_ONE   = 32'(64'd1 << FRAC_BITS);
  localparam logic [DW-1:0] R_HALF = DW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [DW-1:0] R_NINE = DW'(64'd9 << FRAC_BITS);
  localparam logic [DW-1:0] R_FOUR = DW'(64'd4 << FRAC_BITS);
  localparam logic [DW-1:0] R_HUND = DW'(64'd100 << FRAC_BITS);
  localparam logic [GW-1:0] ONE_G  = {1'b1, {FRAC_BITS{1'b0}}};

  state_t state;
  logic [CW-1:0] cnt;
  logic [31:0] est;
  logic [31:0] var_q;

  logic [SAMPLE_BITS-1:0] samp;
  logic [DW-1:0] denom;
  logic [DW-1:0] rem;
  logic [GW-1:0] qreg;
  logic [GW-1:0] gain;
  logic [MW-1:0] mreg;
  logic [AW-1:0] acc;
  logic          up;

  logic [31:0]   q_sel;
  logic [DW-1:0] r_sel;
  logic [SW-1:0] sample_fx;
  logic [AW-1:0] a_op;
  logic [AW-1:0] b_op;
  alu_op_t       op;
  logic [AW:0]   res;
  logic [31:0]   res_sat;

  ksm_alu #(.W(AW)) u_alu (
    .a   (a_op),
    .b   (b_op),
    .op  (op),
    .res (res)
  );

  always_comb begin
    case (mode)
      MODE_8BIT: begin
        q_sel = Q_TENTH;
        r_sel = R_HALF;
      end
      MODE_12BIT: begin
        q_sel = Q_TENTH;
        r_sel = R_NINE;
      end
      MODE_10BIT: begin
        q_sel = Q_TENTH;
        r_sel = R_FOUR;
      end
      default: begin
        q_sel = Q_ONE;
        r_sel = R_HUND;
      end
    endcase
  end

  assign sample_fx = {samp, {FRAC_BITS{1'b0}}};
  assign res_sat   = (|res[AW:32]) ? 32'hFFFF_FFFF : res[31:0];

  // Operand selection for the shared adder.
  always_comb begin
    a_op = '0;
    b_op = '0;
    op   = ALU_ADD;
    case (state)
      ST_PRED: begin
        a_op = AW'(var_q);
        b_op = AW'(q_sel);
      end
      ST_DEN: begin
        a_op = AW'(var_q);
        b_op = AW'(r_sel);
      end
      ST_DINIT: begin
        a_op = AW'(var_q) << FRAC_BITS;
        b_op = AW'(denom >> 1);
      end
      ST_DIV: begin
        a_op = AW'({rem, qreg[GW-1]});
        b_op = AW'(denom);
        op   = ALU_SUB;
      end
      ST_DIFF1: begin
        a_op = AW'(sample_fx);
        b_op = AW'(est);
        op   = ALU_SUB;
      end
      ST_DIFF2: begin
        a_op = AW'(est);
        b_op = AW'(sample_fx);
        op   = ALU_SUB;
      end
      ST_MUL1, ST_MUL2: begin
        a_op = acc << 1;
        b_op = qreg[GW-1] ? AW'(mreg) : '0;
      end
      ST_RND1, ST_RND2: begin
        a_op = acc >> FRAC_BITS;
        b_op = AW'(acc[FRAC_BITS-1]);
      end
      ST_EST: begin
        a_op = AW'(est);
        b_op = acc;
        op   = up ? ALU_ADD : ALU_SUB;
      end
      ST_OMG: begin
        a_op = AW'(ONE_G);
        b_op = AW'(gain);
        op   = ALU_SUB;
      end
      default: begin
        a_op = '0;
      end
    endcase
  end

  // Sequencer and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      est   <= '0;
      var_q <= Q_ONE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_PRED;
          end
        end
        ST_PRED: begin
          var_q <= res_sat;
          state <= ST_DEN;
        end
        ST_DEN: begin
          state <= ST_DINIT;
        end
        ST_DINIT: begin
          cnt   <= CW'(GW - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DIFF1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_DIFF1: begin
          cnt   <= CW'(GW - 1);
          state <= res[AW] ? ST_MUL1 : ST_DIFF2;
        end
        ST_DIFF2: begin
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          if (cnt == '0) begin
            state <= ST_RND1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_RND1: begin
          state <= ST_EST;
        end
        ST_EST: begin
          if (up) begin
            est <= res_sat;
          end else begin
            // A borrow means the correction exceeds the estimate: clamp at zero.
            est <= res[AW] ? res[31:0] : 32'd0;
          end
          state <= ST_OMG;
        end
        ST_OMG: begin
          cnt   <= CW'(GW - 1);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          if (cnt == '0) begin
            state <= ST_RND2;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_RND2: begin
          var_q <= res_sat;
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers of the divider and the multiplier.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          samp <= sample[SAMPLE_BITS-1:0];
        end
      end
      ST_DEN: begin
        denom <= res[DW-1:0];
      end
      ST_DINIT: begin
        // The high part starts the remainder; the low GW bits feed in one per step.
        rem  <= DW'(res[DDW-1:GW]);
        qreg <= res[GW-1:0];
      end
      ST_DIV: begin
        qreg <= {qreg[GW-2:0], res[AW]};
        rem  <= res[AW] ? res[DW-1:0] : {rem[DW-2:0], qreg[GW-1]};
        if (cnt == '0) begin
          gain <= {qreg[GW-2:0], res[AW]};
        end
      end
      ST_DIFF1: begin
        up   <= res[AW];
        mreg <= res[MW-1:0];
        acc  <= '0;
      end
      ST_DIFF2: begin
        mreg <= res[MW-1:0];
      end
      ST_MUL1, ST_MUL2: begin
        acc  <= res[AW-1:0];
        qreg <= qreg << 1;
      end
      ST_RND1: begin
        acc <= res[AW-1:0];
      end
      ST_OMG: begin
        qreg <= res[GW-1:0];
        mreg <= MW'(var_q);
        acc  <= '0;
      end
      default: begin
        up <= up;
      end
    endcase
  end

  assign idle   = (state == ST_IDLE);
  assign done   = (state == ST_HOLD) && out_free;
  assign result = est;

endmodule

// ----- rtl/adc_scalar_kalman_smoother.sv -----
// The result for an accepted input beat is worked out by one shared adder stepping
// through a bit-serial divide and two bit-serial multiplies before its result beat.
// A new sample is taken only once the last one is through: in_ready is low while a
// sample is in work. A finished result waits in an output register.
// Reset clears the estimate to zero, the variance to 1.0 and the mode to 16-bit.
module adc_scalar_kalman_smoother import ksm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] raw_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VALUE_W-1:0]  smoothed_value
);

  logic [1:0]         resolution_mode;
  logic               core_idle;
  logic               core_done;
  logic               out_free;
  logic [VALUE_W-1:0] core_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_mode <= MODE_16BIT;
    end else if (cfg_wr_en) begin
      resolution_mode <= cfg_wr_data;
    end
  end

  assign in_ready = core_idle;
  assign out_free = !out_valid || out_ready;

  ksm_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && core_idle),
    .sample   (raw_sample),
    .mode     (resolution_mode),
    .out_free (out_free),
    .idle     (core_idle),
    .done     (core_done),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      smoothed_value <= core_result;
    end
  end

endmodule

// ----- bench/adc_scalar_kalman_smoother_test.sv -----
`timescale 1ns / 1ps

module adc_scalar_kalman_smoother_test import ksm_pkg::*;;

  localparam int FRAC_BITS = 16;
  localparam bit [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam bit [63:0] TENTH_FX = (ONE_FX + 64'd5) / 64'd10;
  localparam bit [63:0] SAT32 = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 104;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [1:0]          cfg_wr_data = MODE_16BIT;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] raw_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VALUE_W-1:0]  smoothed_value;

  adc_scalar_kalman_smoother dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .raw_sample     (raw_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .smoothed_value (smoothed_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Filter state as the block should hold it.
  logic [1:0]         model_mode = MODE_16BIT;
  logic [VALUE_W-1:0] model_estimate = '0;
  logic [VALUE_W-1:0] model_variance = VALUE_W'(ONE_FX);

  logic [SAMPLE_W-1:0] pending_samples[$];
  logic [VALUE_W-1:0]  expected_estimates[$];
  logic [VALUE_W-1:0]  want_estimate;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int errors = 0;
  int cycle_count = 0;
  int walk_level = 0;

  logic [1:0] mode_codes[4] = '{MODE_8BIT, MODE_12BIT, MODE_10BIT, MODE_16BIT};
  int send_profile[4] = '{0, 58, 0, 9};
  int recv_profile[4] = '{0, 0, 58, 9};

  // One filter step: predict, gain, estimate update, variance shrink.
  function automatic logic [VALUE_W-1:0] kalman_predict(input logic [1:0] mode,
                                                        input logic [SAMPLE_W-1:0] sample);
    bit [63:0] q, r, v, den, gain, smp, est, mag, delta, prod;
    bit up;
    case (mode)
      MODE_8BIT: begin
        q = TENTH_FX;
        r = ONE_FX >> 1;
      end
      MODE_12BIT: begin
        q = TENTH_FX;
        r = 64'd9 * ONE_FX;
      end
      MODE_10BIT: begin
        q = TENTH_FX;
        r = 64'd4 * ONE_FX;
      end
      default: begin
        q = ONE_FX;
        r = 64'd100 * ONE_FX;
      end
    endcase
    v = 64'(model_variance) + q;
    if (v > SAT32) v = SAT32;
    den = v + r;
    gain = ((v << FRAC_BITS) + (den >> 1)) / den;
    if (gain > ONE_FX) gain = ONE_FX;
    smp = 64'(sample) << FRAC_BITS;
    est = 64'(model_estimate);
    up = smp >= est;
    mag = up ? smp - est : est - smp;
    prod = gain * mag;
    delta = (prod >> FRAC_BITS) + ((prod >> (FRAC_BITS - 1)) & 64'd1);
    if (up) begin
      est = est + delta;
      if (est > SAT32) est = SAT32;
    end else begin
      est = (delta > est) ? 64'd0 : est - delta;
    end
    prod = v * (ONE_FX - gain);
    v = (prod >> FRAC_BITS) + ((prod >> (FRAC_BITS - 1)) & 64'd1);
    if (v > SAT32) v = SAT32;
    model_estimate = est[VALUE_W-1:0];
    model_variance = v[VALUE_W-1:0];
    return est[VALUE_W-1:0];
  endfunction

  // Mostly a slowly wandering level with small noise inside the converter's
  // range, plus full-width noise and rail values.
  function automatic logic [SAMPLE_W-1:0] next_sample(input logic [1:0] mode);
    int top, span, pick, s;
    case (mode)
      MODE_8BIT:  top = 255;
      MODE_12BIT: top = 4095;
      MODE_10BIT: top = 1023;
      default:    top = 65535;
    endcase
    span = top / 32 + 1;
    pick = $urandom_range(99);
    if (pick < 10) return SAMPLE_W'($urandom);
    if (pick < 16) return ($urandom_range(1) == 1) ? SAMPLE_W'(top) : '0;
    if (pick < 22) walk_level = $urandom_range(top);
    else walk_level = walk_level + int'($urandom_range(2 * span)) - span;
    if (walk_level < 0) walk_level = 0;
    if (walk_level > top) walk_level = top;
    s = walk_level + int'($urandom_range(2 * span)) - span;
    if (s < 0) s = 0;
    if (s > top) s = top;
    return SAMPLE_W'(s);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_estimates.push_back(kalman_predict(model_mode, raw_sample));
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          raw_sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: actual %h", $time, smoothed_value);
        end else begin
          want_estimate = expected_estimates.pop_front();
          if (smoothed_value !== want_estimate) begin
            errors++;
            $display("%0t: smoothed_value mismatch: expected %h actual %h",
                     $time, want_estimate, smoothed_value);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("adc_scalar_kalman_smoother_test: errors");
      $finish;
    end
  end

  // Called and returning at a falling edge.
  task automatic wait_drained;
    while (pending_samples.size() != 0 || in_valid || expected_estimates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_mode(input logic [1:0] mode);
    wait_drained();
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    model_mode = mode;
  endtask

  initial begin
    logic [1:0] mode;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: rails and large swings in every mode, starting from the reset mode.
    pending_samples = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001};
    write_mode(MODE_8BIT);
    pending_samples = '{16'h00FF, 16'h0000, 16'h00FF, 16'h0080};
    write_mode(MODE_12BIT);
    pending_samples = '{16'h0FFF, 16'h0000, 16'h0FFF, 16'h0800};
    write_mode(MODE_10BIT);
    pending_samples = '{16'h03FF, 16'h0000, 16'h03FF, 16'h0200};
    write_mode(MODE_16BIT);
    pending_samples = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555};

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = (p < 4) ? mode_codes[p] : mode_codes[$urandom_range(3)];
      write_mode(mode);
      send_idle_pct  = send_profile[p % 4];
      recv_stall_pct = recv_profile[p % 4];
      // The first phase starts with a long output stall while samples keep coming.
      if (p == 0) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pending_samples.push_back(next_sample(mode));
      end
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("adc_scalar_kalman_smoother_test: clean");
    end else begin
      $display("adc_scalar_kalman_smoother_test: errors");
    end
    $finish;
  end

endmodule
